### hdl/slp_pkg.sv
// Shared constants, codes and types of the system call latency profiler.
`timescale 1ns / 1ps

package slp_pkg;

  localparam int TableDepthDef = 512;
  localparam int ChildSlotsDef = 64;

  localparam int DataW      = 64;
  localparam int PidW       = 23;
  localparam int ThreadPidW = 32;
  localparam int CallW      = 10;
  localparam int CmdW       = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 23;

  localparam logic [CallW-1:0] RestartCall = 10'd219;

  // Kernel restart return codes, as two's complement words.
  localparam logic [DataW-1:0] RetRestartSys      = 64'hFFFF_FFFF_FFFF_FE00;
  localparam logic [DataW-1:0] RetRestartNoIntr   = 64'hFFFF_FFFF_FFFF_FDFF;
  localparam logic [DataW-1:0] RetRestartNoHand   = 64'hFFFF_FFFF_FFFF_FDFE;
  localparam logic [DataW-1:0] RetRestartBlock    = 64'hFFFF_FFFF_FFFF_FDFC;

  typedef enum logic [CmdW-1:0] {
    CmdEnter = 3'd0,
    CmdExit  = 3'd1,
    CmdFork  = 3'd2,
    CmdPexit = 3'd3,
    CmdRead  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFilterEn  = 3'd0,
    RegTracedPid = 3'd1,
    RegFollowEn  = 3'd2,
    RegOwnPid    = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StExec,
    StTable,
    StDone
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic [DataW-1:0]        thread_id;
    logic [CallW-1:0]        call_id;
    logic signed [DataW-1:0] return_value;
    logic [DataW-1:0]        timestamp;
    logic [PidW-1:0]         parent_pid;
    logic [PidW-1:0]         child_pid;
  } in_item_t;

  typedef struct packed {
    logic             applied;
    logic             set_full;
    logic [DataW-1:0] call_count;
    logic [DataW-1:0] total_time;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [ThreadPidW-1:0] pid;
    logic [PidW-1:0]       ppid;
    logic [PidW-1:0]       cpid;
  } child_key_t;

  typedef struct packed {
    logic hit_pid;
    logic hit_ppid;
    logic hit_cpid;
    logic free_found;
  } child_res_t;

  typedef struct packed {
    logic set_slot;
    logic clr_slot;
  } child_upd_t;

  typedef struct packed {
    logic [DataW-1:0] count;
    logic [DataW-1:0] total;
  } stat_entry_t;

endpackage

### hdl/slp_if.sv
// Handshake interfaces for the event, result and configuration channels.
`timescale 1ns / 1ps

interface slp_in_if
  import slp_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface slp_out_if
  import slp_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface slp_cfg_if
  import slp_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hdl/slp_child_set.sv
// Child process set: valid flags, pid memory and a sequential lookup scan.
`timescale 1ns / 1ps

module slp_child_set
  import slp_pkg::*;
#(
  parameter int  ChildSlots = ChildSlotsDef,
  localparam int SlotW      = (ChildSlots > 1) ? $clog2(ChildSlots) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  child_key_t       key_i,
  output logic             done_o,
  output child_res_t       res_o,
  output logic [SlotW-1:0] pid_slot_o,
  output logic [SlotW-1:0] free_slot_o,
  input  child_upd_t       upd_i,
  input  logic [SlotW-1:0] upd_slot_i,
  input  logic [PidW-1:0]  upd_pid_i
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(ChildSlots - 1);

  logic [ChildSlots-1:0] valid_q, valid_d;
  logic [PidW-1:0]       pid_mem [ChildSlots];
  logic [PidW-1:0]       rd_pid_q;

  logic             iss_act_q, iss_act_d;
  logic [SlotW-1:0] iss_idx_q, iss_idx_d;
  logic             cmp_act_q, cmp_act_d;
  logic [SlotW-1:0] cmp_idx_q, cmp_idx_d;
  logic             done_q, done_d;

  child_key_t       key_q;
  logic             key_small_q;
  child_res_t       res_q, res_d;
  logic [SlotW-1:0] pid_slot_q, pid_slot_d;
  logic [SlotW-1:0] free_slot_q, free_slot_d;
  logic             slot_valid;

  always_ff @(posedge clk_i) begin
    if (upd_i.set_slot) begin
      pid_mem[upd_slot_i] <= upd_pid_i;
    end
    if (iss_act_q) begin
      rd_pid_q <= pid_mem[iss_idx_q];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (upd_i.set_slot) begin
      valid_d[upd_slot_i] = 1'b1;
    end
    if (upd_i.clr_slot) begin
      valid_d[upd_slot_i] = 1'b0;
    end
  end

  // Reads are issued one slot per cycle; each slot is compared in the cycle after its read.
  always_comb begin
    iss_act_d   = iss_act_q;
    iss_idx_d   = iss_idx_q;
    cmp_act_d   = iss_act_q;
    cmp_idx_d   = iss_idx_q;
    res_d       = res_q;
    pid_slot_d  = pid_slot_q;
    free_slot_d = free_slot_q;
    done_d      = 1'b0;
    slot_valid  = valid_q[cmp_idx_q];
    if (start_i) begin
      iss_act_d   = 1'b1;
      iss_idx_d   = '0;
      res_d       = '0;
      pid_slot_d  = '0;
      free_slot_d = '0;
    end else if (iss_act_q) begin
      if (iss_idx_q == LastSlot) begin
        iss_act_d = 1'b0;
      end else begin
        iss_idx_d = iss_idx_q + 1'b1;
      end
    end
    if (cmp_act_q) begin
      if (slot_valid) begin
        if (key_small_q && (rd_pid_q == key_q.pid[PidW-1:0]) && !res_q.hit_pid) begin
          res_d.hit_pid = 1'b1;
          pid_slot_d    = cmp_idx_q;
        end
        if (rd_pid_q == key_q.ppid) begin
          res_d.hit_ppid = 1'b1;
        end
        if (rd_pid_q == key_q.cpid) begin
          res_d.hit_cpid = 1'b1;
        end
      end else if (!res_q.free_found) begin
        res_d.free_found = 1'b1;
        free_slot_d      = cmp_idx_q;
      end
      if (cmp_idx_q == LastSlot) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      iss_act_q <= 1'b0;
      iss_idx_q <= '0;
      cmp_act_q <= 1'b0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      iss_act_q <= iss_act_d;
      iss_idx_q <= iss_idx_d;
      cmp_act_q <= cmp_act_d;
      cmp_idx_q <= cmp_idx_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q       <= key_i;
      key_small_q <= (key_i.pid[ThreadPidW-1:PidW] == '0);
    end
    res_q       <= res_d;
    pid_slot_q  <= pid_slot_d;
    free_slot_q <= free_slot_d;
  end

  assign done_o      = done_q;
  assign res_o       = res_q;
  assign pid_slot_o  = pid_slot_q;
  assign free_slot_o = free_slot_q;

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> iss_act_q)
    else $error("child scan did not start");

  a_no_update_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i.set_slot || upd_i.clr_slot) |-> !(iss_act_q || cmp_act_q || start_i))
    else $error("child set updated during a scan");

endmodule

### hdl/slp_stat_table.sv
// Per-call statistics memory with a clearing pass after reset.
`timescale 1ns / 1ps

module slp_stat_table
  import slp_pkg::*;
#(
  parameter int  TableDepth = TableDepthDef,
  localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             ready_o,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output stat_entry_t      rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  stat_entry_t      wr_data_i
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TableDepth - 1);

  stat_entry_t      mem [TableDepth];
  stat_entry_t      rd_data_q;
  logic             clearing_q, clearing_d;
  logic [AddrW-1:0] clr_idx_q, clr_idx_d;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  stat_entry_t      wr_data;

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      if (clr_idx_q == LastAddr) begin
        clearing_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
    wr_en   = clearing_q || wr_en_i;
    wr_addr = clearing_q ? clr_idx_q : wr_addr_i;
    wr_data = clearing_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign ready_o   = !clearing_q;
  assign rd_data_o = rd_data_q;

  a_no_access_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i || wr_en_i) |-> !clearing_q)
    else $error("statistics access during clearing pass");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_idx_q) == LastAddr))
    else $error("clearing pass ended early");

endmodule

### hdl/syscall_latency_profiler_top.sv
// Top level of the system call count and latency profiler.
//
//   Port    Dir   Payload      Role
//   cfg_i   in    cfg_item_t   register writes, always ready
//   in_i    in    in_item_t    events: enter, exit, fork, process exit, read
//   out_o   out   out_item_t   one result item per event
//
// An item runs an execute step and, when it reads or updates the statistics
// memory, a table step (one read, one write back). When the child set is
// consulted (follow on, and for enter/exit also filter on and a pid other
// than the traced one) a scan of the pid memory comes first. After reset the
// statistics memory is cleared in full before the first item is taken.
// One finished result waits in the output register; the next item is taken
// meanwhile but completes only after that result is accepted.
`timescale 1ns / 1ps

module syscall_latency_profiler_top
  import slp_pkg::*;
#(
  parameter int TableDepth = TableDepthDef,
  parameter int ChildSlots = ChildSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slp_cfg_if.sink   cfg_i,
  slp_in_if.sink    in_i,
  slp_out_if.source out_o
);

  localparam int SlotW = (ChildSlots > 1) ? $clog2(ChildSlots) : 1;
  localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [CallW:0] DepthLim = (CallW + 1)'(TableDepth);
  localparam int PidPadW = ThreadPidW - PidW;

  // Configuration registers.
  logic            filter_en_q;
  logic [PidW-1:0] traced_pid_q;
  logic            follow_en_q;
  logic [PidW-1:0] own_pid_q;

  state_e state_q, state_d;

  in_item_t         item_q;
  logic             scanned_q, scanned_d;
  logic [DataW-1:0] pend_thread_q, pend_start_q;
  logic [DataW-1:0] diff_q;
  out_item_t        res_q, res_d;
  out_item_t        out_q;
  logic             out_valid_q, out_valid_d;

  logic in_acc, out_acc, load_out;
  logic need_scan, start_scan;
  logic [ThreadPidW-1:0] pid_in, pid_c;
  child_key_t scan_key;

  logic             scan_done;
  child_res_t       cres;
  logic [SlotW-1:0] pid_slot, free_slot;
  child_upd_t       upd;

  logic        tbl_ready;
  logic        tbl_rd, tbl_wr;
  stat_entry_t tbl_rd_data, tbl_wr_data;

  logic is_traced, is_own, passes, restart, in_range, tid_match, ppid_ok;
  logic hit_pid, hit_ppid, hit_cpid, free_found;
  logic pend_set, pend_clr;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q  <= 1'b0;
      traced_pid_q <= '0;
      follow_en_q  <= 1'b0;
      own_pid_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.item.index)
        RegFilterEn:  filter_en_q  <= cfg_i.item.data[0];
        RegTracedPid: traced_pid_q <= cfg_i.item.data[PidW-1:0];
        RegFollowEn:  follow_en_q  <= cfg_i.item.data[0];
        RegOwnPid:    own_pid_q    <= cfg_i.item.data[PidW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- scan request at accept ----------------
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_valid_q && out_o.ready;
  assign pid_in  = in_i.item.thread_id[DataW-1:DataW-ThreadPidW];

  always_comb begin
    case (in_i.item.command)
      CmdEnter, CmdExit:
        need_scan = filter_en_q && follow_en_q && (pid_in != {{PidPadW{1'b0}}, traced_pid_q});
      CmdFork, CmdPexit:
        need_scan = follow_en_q;
      default:
        need_scan = 1'b0;
    endcase
  end

  assign start_scan    = in_acc && need_scan;
  assign scan_key.pid  = pid_in;
  assign scan_key.ppid = in_i.item.parent_pid;
  assign scan_key.cpid = in_i.item.child_pid;

  slp_child_set #(
    .ChildSlots (ChildSlots)
  ) u_child (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_scan),
    .key_i       (scan_key),
    .done_o      (scan_done),
    .res_o       (cres),
    .pid_slot_o  (pid_slot),
    .free_slot_o (free_slot),
    .upd_i       (upd),
    .upd_slot_i  (upd.set_slot ? free_slot : pid_slot),
    .upd_pid_i   (item_q.child_pid)
  );

  slp_stat_table #(
    .TableDepth (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ready_o   (tbl_ready),
    .rd_en_i   (tbl_rd),
    .rd_addr_i (item_q.call_id[AddrW-1:0]),
    .rd_data_o (tbl_rd_data),
    .wr_en_i   (tbl_wr),
    .wr_addr_i (item_q.call_id[AddrW-1:0]),
    .wr_data_i (tbl_wr_data)
  );

  // ---------------- decision terms ----------------
  // Scan results only count when this item actually ran a scan.
  assign hit_pid    = scanned_q && cres.hit_pid;
  assign hit_ppid   = scanned_q && cres.hit_ppid;
  assign hit_cpid   = scanned_q && cres.hit_cpid;
  assign free_found = scanned_q && cres.free_found;

  assign pid_c     = item_q.thread_id[DataW-1:DataW-ThreadPidW];
  assign is_traced = (pid_c == {{PidPadW{1'b0}}, traced_pid_q});
  assign is_own    = (pid_c == {{PidPadW{1'b0}}, own_pid_q});
  assign passes    = (!filter_en_q || is_traced || (follow_en_q && hit_pid)) && !is_own;
  assign restart   = (item_q.call_id == RestartCall)
                  || (item_q.return_value == RetRestartSys)
                  || (item_q.return_value == RetRestartNoIntr)
                  || (item_q.return_value == RetRestartNoHand)
                  || (item_q.return_value == RetRestartBlock);
  assign in_range  = ({1'b0, item_q.call_id} < DepthLim);
  assign tid_match = (item_q.thread_id == pend_thread_q);
  assign ppid_ok   = (item_q.parent_pid == traced_pid_q) || hit_ppid;

  assign tbl_wr_data.count = tbl_rd_data.count + 1'b1;
  assign tbl_wr_data.total = tbl_rd_data.total + diff_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = need_scan ? StScan : StExec;
        end
      end
      StScan: begin
        if (scan_done) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = tbl_rd ? StTable : StDone;
      end
      StTable: begin
        state_d = StDone;
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // ---------------- outputs of the state machine ----------------
  always_comb begin
    in_i.ready   = 1'b0;
    tbl_rd       = 1'b0;
    tbl_wr       = 1'b0;
    upd          = '0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    load_out     = 1'b0;
    res_d        = res_q;
    scanned_d    = scanned_q;
    case (state_q)
      StIdle: begin
        in_i.ready = tbl_ready;
        if (in_i.valid && tbl_ready) begin
          scanned_d = need_scan;
        end
      end
      StExec: begin
        res_d = '0;
        case (item_q.command)
          CmdEnter: begin
            if (passes) begin
              pend_set      = 1'b1;
              res_d.applied = 1'b1;
            end
          end
          CmdExit: begin
            if (!restart && passes) begin
              if (!in_range) begin
                pend_clr      = 1'b1;
                res_d.applied = 1'b1;
              end else if (tid_match) begin
                tbl_rd        = 1'b1;
                pend_clr      = 1'b1;
                res_d.applied = 1'b1;
              end
            end
          end
          CmdFork: begin
            if (follow_en_q && ppid_ok && !hit_cpid) begin
              if (free_found) begin
                upd.set_slot  = 1'b1;
                res_d.applied = 1'b1;
              end else begin
                res_d.set_full = 1'b1;
              end
            end
          end
          CmdPexit: begin
            if (follow_en_q && hit_pid) begin
              upd.clr_slot  = 1'b1;
              res_d.applied = 1'b1;
            end
          end
          CmdRead: begin
            tbl_rd = in_range;
          end
          default: ;
        endcase
      end
      StTable: begin
        if (item_q.command == CmdExit) begin
          tbl_wr = 1'b1;
        end else begin
          res_d.call_count = tbl_rd_data.count;
          res_d.total_time = tbl_rd_data.total;
        end
      end
      StDone: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      scanned_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      pend_thread_q <= '0;
      pend_start_q  <= '0;
    end else begin
      state_q     <= state_d;
      scanned_q   <= scanned_d;
      out_valid_q <= out_valid_d;
      if (pend_set) begin
        pend_thread_q <= item_q.thread_id;
        pend_start_q  <= item_q.timestamp;
      end else if (pend_clr) begin
        pend_thread_q <= '0;
        pend_start_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.item;
    end
    if (state_q == StExec) begin
      diff_q <= item_q.timestamp - pend_start_q;
    end
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("second item accepted while one is in flight");

  a_full_not_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.item.applied && out_o.item.set_full))
    else $error("result marks both applied and set full");

  a_table_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTable) |-> ($past(state_q) == StExec) && $past(tbl_rd))
    else $error("table stage entered without a read");

endmodule

### tb/tb.sv
// Self-checking testbench for the system call latency profiler top level.
`timescale 1ns / 1ps

module tb;
  import slp_pkg::*;

  localparam int KidPool = 80;
  localparam int PidMax  = 4194304;

  // Tracks the profiler state and the result item each accepted event should produce.
  class profiler_scoreboard;
    bit             filter_en;
    bit             follow_en;
    bit [PidW-1:0]  traced_pid;
    bit [PidW-1:0]  own_pid;
    bit [DataW-1:0] pend_thread;
    bit [DataW-1:0] pend_start;
    bit [DataW-1:0] call_counts [TableDepthDef];
    bit [DataW-1:0] call_times  [TableDepthDef];
    bit             child_used  [ChildSlotsDef];
    bit [PidW-1:0]  child_pid   [ChildSlotsDef];
    out_item_t      awaited_results [$];
    int             fail_count;

    function void write_reg(cfg_reg_e idx, bit [CfgDataW-1:0] data);
      case (idx)
        RegFilterEn:  filter_en  = data[0];
        RegTracedPid: traced_pid = data;
        RegFollowEn:  follow_en  = data[0];
        RegOwnPid:    own_pid    = data;
        default: ;
      endcase
    endfunction

    function int find_child(bit [ThreadPidW-1:0] pid);
      for (int i = 0; i < ChildSlotsDef; i++) begin
        if (child_used[i] && 32'(child_pid[i]) == pid) return i;
      end
      return -1;
    endfunction

    function bit process_passes(bit [DataW-1:0] tid);
      bit [ThreadPidW-1:0] pid;
      pid = tid[63:32];
      if (filter_en && pid != 32'(traced_pid) && !(follow_en && find_child(pid) >= 0)) begin
        return 1'b0;
      end
      return pid != 32'(own_pid);
    endfunction

    function void clear_pending();
      pend_thread = '0;
      pend_start  = '0;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t r;
      bit        restart;
      int        slot;
      r = '0;
      case (ev.command)
        CmdEnter: begin
          if (process_passes(ev.thread_id)) begin
            pend_thread = ev.thread_id;
            pend_start  = ev.timestamp;
            r.applied   = 1'b1;
          end
        end
        CmdExit: begin
          restart = ev.call_id == RestartCall ||
                    ev.return_value == RetRestartSys || ev.return_value == RetRestartNoIntr ||
                    ev.return_value == RetRestartNoHand || ev.return_value == RetRestartBlock;
          if (!restart && process_passes(ev.thread_id)) begin
            // Out-of-range calls drop the pending record without a thread check.
            if (ev.call_id >= TableDepthDef) begin
              clear_pending();
              r.applied = 1'b1;
            end else if (ev.thread_id == pend_thread) begin
              call_counts[ev.call_id] += 1;
              call_times[ev.call_id]  += ev.timestamp - pend_start;
              clear_pending();
              r.applied = 1'b1;
            end
          end
        end
        CmdFork: begin
          if (follow_en && (ev.parent_pid == traced_pid || find_child(32'(ev.parent_pid)) >= 0)
              && find_child(32'(ev.child_pid)) < 0) begin
            slot = -1;
            for (int i = 0; i < ChildSlotsDef; i++) begin
              if (!child_used[i]) begin
                slot = i;
                break;
              end
            end
            if (slot >= 0) begin
              child_used[slot] = 1'b1;
              child_pid[slot]  = ev.child_pid;
              r.applied        = 1'b1;
            end else begin
              r.set_full = 1'b1;
            end
          end
        end
        CmdPexit: begin
          if (follow_en) begin
            slot = find_child(ev.thread_id[63:32]);
            if (slot >= 0) begin
              child_used[slot] = 1'b0;
              r.applied        = 1'b1;
            end
          end
        end
        CmdRead: begin
          if (ev.call_id < TableDepthDef) begin
            r.call_count = call_counts[ev.call_id];
            r.total_time = call_times[ev.call_id];
          end
        end
        default: ;
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: applied=%0b full=%0b count=%0h time=%0h",
                   got.applied, got.set_full, got.call_count, got.total_time);
        end
        return;
      end
      want = awaited_results.pop_front();
      if (got.applied !== want.applied || got.set_full !== want.set_full ||
          got.call_count !== want.call_count || got.total_time !== want.total_time) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result mismatch: expected applied=%0b full=%0b count=%0h time=%0h",
                   want.applied, want.set_full, want.call_count, want.total_time);
          $display("                 actual   applied=%0b full=%0b count=%0h time=%0h",
                   got.applied, got.set_full, got.call_count, got.total_time);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  slp_cfg_if cfg_if ();
  slp_in_if  in_if ();
  slp_out_if out_if ();

  syscall_latency_profiler_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  profiler_scoreboard sb;
  bit                 idling;
  bit                 rx_hold;
  bit [DataW-1:0]     clock_ns;
  bit [PidW-1:0]      kid_pool [KidPool];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random short stalls, plus the long hold-off when requested.
  initial begin
    int gap;
    gap          = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (gap > 0) begin
        out_if.ready <= 1'b0;
        gap--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        gap = $urandom_range(0, 2);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.item);
  end

  function automatic bit [PidW-1:0] rand_pid();
    return PidW'($urandom_range(0, PidMax));
  endfunction

  function automatic bit [DataW-1:0] tick();
    if ($urandom_range(0, 49) == 0) clock_ns = {$urandom, $urandom};
    else clock_ns += $urandom_range(1, 5000);
    return clock_ns;
  endfunction

  function automatic in_item_t make_event(bit [CmdW-1:0] cmd, bit [DataW-1:0] tid,
                                          bit [CallW-1:0] call, bit [DataW-1:0] ret,
                                          bit [DataW-1:0] ts);
    in_item_t ev;
    ev.command      = cmd;
    ev.thread_id    = tid;
    ev.call_id      = call;
    ev.return_value = ret;
    ev.timestamp    = ts;
    ev.parent_pid   = rand_pid();
    ev.child_pid    = rand_pid();
    return ev;
  endfunction

  function automatic bit [ThreadPidW-1:0] pick_process();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'(sb.traced_pid);
      4, 5, 6:    return 32'(kid_pool[$urandom_range(0, KidPool - 1)]);
      7:          return 32'(sb.own_pid);
      8:          return $urandom_range(0, PidMax);
      default:    return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] pick_thread();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic bit [CallW-1:0] pick_call();
    case ($urandom_range(0, 19))
      0:       return RestartCall;
      1:       return CallW'($urandom_range(TableDepthDef, 1023));
      2, 3:    return CallW'($urandom_range(0, TableDepthDef - 1));
      default: return CallW'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic bit [DataW-1:0] pick_ret();
    case ($urandom_range(0, 19))
      0:       return RetRestartSys;
      1:       return RetRestartNoIntr;
      2:       return RetRestartNoHand;
      3:       return RetRestartBlock;
      4:       return {$urandom, $urandom};
      5:       return -64'sd515;
      default: return 64'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic bit [CfgDataW-1:0] pick_cfg_pid();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return CfgDataW'(PidMax);
      default: return CfgDataW'($urandom_range(1, PidMax - 1));
    endcase
  endfunction

  task automatic send_event(in_item_t ev);
    if (idling && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.item  <= ev;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_event(ev);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [CfgDataW-1:0] data);
    cfg_item_t w;
    w.index = idx;
    w.data  = data;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.item  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop sending and drain every outstanding result before returning.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic apply_config(bit filt, bit [CfgDataW-1:0] traced, bit follow,
                              bit [CfgDataW-1:0] own);
    drain();
    write_reg(RegFilterEn, CfgDataW'(filt));
    write_reg(RegTracedPid, traced);
    write_reg(RegFollowEn, CfgDataW'(follow));
    write_reg(RegOwnPid, own);
  endtask

  task automatic hold_receiver(int cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold = 1'b0;
  endtask

  task automatic run_directed();
    bit [DataW-1:0] t_a;
    bit [DataW-1:0] t_max;
    in_item_t       ev;
    t_a   = 64'h0000_0001_0000_0002;
    t_max = '1;
    send_event(make_event(CmdRead, t_a, 10'd0, '0, '0));
    send_event(make_event(CmdRead, t_a, 10'd1023, '0, '0));
    // Thread zero with nothing pending still counts, from start time zero.
    send_event(make_event(CmdExit, '0, 10'd3, '0, 64'd100));
    send_event(make_event(CmdEnter, t_a, 10'd0, '0, 64'hFFFF_FFFF_FFFF_FF00));
    send_event(make_event(CmdExit, t_a, 10'd511, 64'h8000_0000_0000_0000, 64'h10));
    send_event(make_event(CmdEnter, t_max, 10'd0, '0, '0));
    send_event(make_event(CmdExit, t_a, 10'd7, '0, 64'd50));
    send_event(make_event(CmdExit, t_max, RestartCall, '0, 64'd60));
    send_event(make_event(CmdExit, t_max, 10'd7, RetRestartSys, 64'd61));
    send_event(make_event(CmdExit, t_max, 10'd7, RetRestartNoIntr, 64'd62));
    send_event(make_event(CmdExit, t_max, 10'd7, RetRestartNoHand, 64'd63));
    send_event(make_event(CmdExit, t_max, 10'd7, RetRestartBlock, 64'd64));
    send_event(make_event(CmdExit, t_max, 10'd7, -64'sd515, t_max));
    send_event(make_event(CmdEnter, t_a, 10'd0, '0, 64'd5));
    send_event(make_event(CmdExit, t_a, 10'd1023, 64'h7FFF_FFFF_FFFF_FFFF, 64'd9));
    send_event(make_event(CmdExit, t_a, 10'd8, '0, 64'd20));
    send_event(make_event(CmdEnter, {32'(PidMax), 32'd1}, 10'd0, '0, 64'd30));
    ev = make_event(CmdFork, t_a, 10'd0, '0, '0);
    ev.parent_pid = PidW'(PidMax);
    ev.child_pid  = '0;
    send_event(ev);
    send_event(make_event(CmdPexit, {32'(PidMax), 32'd0}, 10'd0, '0, '0));
    send_event(make_event(3'd5, t_max, 10'd1023, t_max, t_max));
    send_event(make_event(3'd6, '0, 10'd0, '0, '0));
    send_event(make_event(3'd7, t_a, 10'd511, '0, 64'd1));
    send_event(make_event(CmdRead, t_a, 10'd511, '0, '0));
    send_event(make_event(CmdRead, t_a, 10'd7, '0, '0));
    send_event(make_event(CmdRead, t_a, 10'd3, '0, '0));
  endtask

  task automatic run_random(int n_items);
    int             sent;
    int             k;
    bit [DataW-1:0] tid;
    in_item_t       ev;
    sent = 0;
    while (sent < n_items) begin
      k   = $urandom_range(0, 99);
      tid = {pick_process(), pick_thread()};
      if (k < 45) begin
        send_event(make_event(CmdEnter, tid, pick_call(), pick_ret(), tick()));
        // Now and then the exit comes from another thread of the same process.
        if (k < 4) tid[3:0] = ~tid[3:0];
        send_event(make_event(CmdExit, tid, pick_call(), pick_ret(), tick()));
        sent += 2;
      end else if (k < 60) begin
        ev = make_event(CmdFork, tid, pick_call(), pick_ret(), tick());
        if ($urandom_range(0, 2) == 0) ev.parent_pid = sb.traced_pid;
        else if ($urandom_range(0, 3) != 0) ev.parent_pid = kid_pool[$urandom_range(0, KidPool - 1)];
        ev.child_pid = kid_pool[$urandom_range(0, KidPool - 1)];
        send_event(ev);
        sent++;
      end else if (k < 67) begin
        if ($urandom_range(0, 3) == 0) tid[63:32] = 32'(sb.traced_pid);
        else tid[63:32] = 32'(kid_pool[$urandom_range(0, KidPool - 1)]);
        send_event(make_event(CmdPexit, tid, pick_call(), pick_ret(), tick()));
        sent++;
      end else if (k < 80) begin
        send_event(make_event(CmdRead, tid,
                              ($urandom_range(0, 3) == 0) ? CallW'($urandom_range(0, 1023))
                                                          : CallW'($urandom_range(0, 15)),
                              pick_ret(), tick()));
        sent++;
      end else if (k < 92) begin
        send_event(make_event(CmdW'($urandom_range(0, 7)), {$urandom, $urandom},
                              CallW'($urandom_range(0, 1023)), {$urandom, $urandom},
                              {$urandom, $urandom}));
        sent++;
      end else begin
        send_event(make_event((k < 96) ? CmdEnter : CmdExit, tid, pick_call(), pick_ret(),
                              tick()));
        sent++;
      end
    end
  endtask

  initial begin
    in_item_t ev;
    sb           = new();
    rst_ni       = 1'b0;
    idling       = 1'b0;
    rx_hold      = 1'b0;
    clock_ns     = '0;
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.item  = '0;
    kid_pool[0]  = '0;
    kid_pool[1]  = PidW'(PidMax);
    for (int i = 2; i < KidPool; i++) kid_pool[i] = PidW'($urandom_range(1, PidMax - 1));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apply_config(1'b0, CfgDataW'(PidMax), 1'b0, CfgDataW'(PidMax));
    run_directed();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_config(1'b1, CfgDataW'($urandom_range(1, PidMax - 1)), 1'b1, '0);
        1: apply_config(1'b1, CfgDataW'(PidMax), 1'b1, pick_cfg_pid());
        2: apply_config(1'b0, '0, 1'b0, CfgDataW'(PidMax));
        3: apply_config(1'b1, '0, 1'b1, CfgDataW'(PidMax));
        default: apply_config(1'($urandom_range(0, 1)), pick_cfg_pid(),
                              1'($urandom_range(0, 1)), pick_cfg_pid());
      endcase
      idling = (p % 3 != 2) && (p != 7);
      if (p == 0) begin
        // Fill the child set from the traced process until it overflows.
        for (int i = 0; i < ChildSlotsDef + 2; i++) begin
          ev = make_event(CmdFork, {$urandom, $urandom}, '0, '0, tick());
          ev.parent_pid = sb.traced_pid;
          ev.child_pid  = kid_pool[i];
          send_event(ev);
        end
      end
      if (p == 1) begin
        // Long result stall while events keep coming, so the input backs up.
        idling = 1'b0;
        fork
          hold_receiver(400);
        join_none
        repeat (40) send_event(make_event(CmdRead, tick(), CallW'($urandom_range(0, 15)),
                                          '0, '0));
        idling = 1'b1;
      end
      run_random(250);
    end

    drain();
    if (sb.fail_count == 0 && sb.awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/slp_pkg.sv
hdl/slp_if.sv
hdl/slp_child_set.sv
hdl/slp_stat_table.sv
hdl/syscall_latency_profiler_top.sv
tb/tb.sv
